### hw/rtl/stereo_mixer_bandpass_macros.svh
// assertion macros for the stereo mixer block
// expects clk and rst in the scope of each use
`ifndef STEREO_MIXER_BANDPASS_MACROS_SVH
`define STEREO_MIXER_BANDPASS_MACROS_SVH
`ifndef ASSERT_OFF
`define SMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SMB_ASSERT_IMP(lbl, ante, cons, msg)
`define SMB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/smb_pkg.sv
// shared widths, register indexes and types of the stereo mixer
// no dependencies
package smb_pkg;

  localparam int NUM_CH      = 4;
  localparam int LEVEL_W     = 16;
  localparam int SUM_W       = 18;
  localparam int X_W         = 17;
  localparam int CAP_W       = 20;
  localparam int COEF_W      = 16;
  localparam int VOL_W       = 3;
  localparam int PAN_W       = 8;
  localparam int OUT_W       = 16;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [REG_IDX_W-1:0] REG_PAN_ROUTE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_VOLUME  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_VOLUME = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HP_COEF      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LP_COEF      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SOUND_EN     = 3'd5;

  localparam logic [COEF_W-1:0] HP_COEF_RESET = 16'd65402;
  localparam logic [COEF_W-1:0] LP_COEF_RESET = 16'd32768;

  typedef struct packed {
    logic [PAN_W-1:0]  pan_route;
    logic [VOL_W-1:0]  left_volume;
    logic [VOL_W-1:0]  right_volume;
    logic [COEF_W-1:0] hp_coef;
    logic [COEF_W-1:0] lp_coef;
    logic              sound_en;
  } cfg_t;

  typedef struct packed {
    logic                  clear;
    logic signed [X_W-1:0] left_x;
    logic signed [X_W-1:0] right_x;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hw/rtl/smb_front.sv
// front end: takes requests, mixes and scales both sides, stages a job
// depends on smb_pkg
module smb_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  smb_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [smb_pkg::NUM_CH*smb_pkg::LEVEL_W-1:0] levels,
  input  logic                                   dacs_on,
  input  smb_pkg::qstat_t                        qstat,
  output logic                                   push,
  output smb_pkg::job_t                          job
);

  logic          stage_valid;
  smb_pkg::job_t stage;
  smb_pkg::job_t job_next;
  logic signed [smb_pkg::SUM_W-1:0] lsum;
  logic signed [smb_pkg::SUM_W-1:0] rsum;
  logic accept;

  function automatic logic signed [smb_pkg::X_W-1:0] scale_side(
    input logic signed [smb_pkg::SUM_W-1:0] s,
    input logic [smb_pkg::VOL_W-1:0]        vol
  );
    logic [smb_pkg::VOL_W:0] vp1;
    logic signed [21:0]      prod;
    logic signed [21:0]      neg;
    vp1  = {1'b0, vol} + 4'd1;
    prod = 22'(s) * $signed({18'd0, vp1});
    neg  = 22'sd16 - prod;
    return neg[21:5];
  endfunction

  function automatic logic signed [smb_pkg::SUM_W-1:0] SUM_W_EXT(
    input logic [smb_pkg::LEVEL_W-1:0] v
  );
    return smb_pkg::SUM_W'($signed(v));
  endfunction

  always_comb begin
    lsum = '0;
    rsum = '0;
    for (int i = 0; i < smb_pkg::NUM_CH; i++) begin
      if (cfg.pan_route[i]) begin
        rsum = rsum + SUM_W_EXT(levels[i*smb_pkg::LEVEL_W +: smb_pkg::LEVEL_W]);
      end
      if (cfg.pan_route[i+smb_pkg::NUM_CH]) begin
        lsum = lsum + SUM_W_EXT(levels[i*smb_pkg::LEVEL_W +: smb_pkg::LEVEL_W]);
      end
    end
  end

  always_comb begin
    job_next.clear   = ~dacs_on;
    job_next.left_x  = scale_side(lsum, cfg.left_volume);
    job_next.right_x = scale_side(rsum, cfg.right_volume);
  end

  assign push     = stage_valid && !qstat.full;
  assign in_ready = !stage_valid || !qstat.full;
  assign accept   = in_valid && in_ready;
  assign job      = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= cfg.sound_en;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= job_next;
    end
  end

endmodule

### hw/rtl/smb_queue.sv
// two-entry job queue between front and back end
// depends on smb_pkg
module smb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smb_pkg::job_t   wr_job,
  input  logic            pop,
  output smb_pkg::job_t   rd_job,
  output smb_pkg::qstat_t qstat
);

  smb_pkg::job_t entries [smb_pkg::QUEUE_DEPTH];
  logic [smb_pkg::QPTR_W-1:0] wr_ptr;
  logic [smb_pkg::QPTR_W-1:0] rd_ptr;
  logic [smb_pkg::QPTR_W:0]   count;

  assign qstat.full  = (count == (smb_pkg::QPTR_W+1)'(smb_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_job      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### hw/rtl/smb_back.sv
// back end: high-pass and low-pass caps on one shared multiplier, output register
// depends on smb_pkg
module smb_back (
  input  logic                    clk,
  input  logic                    rst,
  input  smb_pkg::cfg_t           cfg,
  input  smb_pkg::job_t           head,
  input  smb_pkg::qstat_t         qstat,
  output logic                    pop,
  output logic                    emit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*smb_pkg::OUT_W-1:0] out_data
);

  localparam logic [2:0] LAST_PHASE = 3'd7;

  logic          busy;
  logic [2:0]    phase;
  smb_pkg::job_t cur;
  logic signed [smb_pkg::CAP_W-1:0] lhp, llp, rhp, rlp;
  logic signed [38:0]               prod;
  logic [smb_pkg::OUT_W-1:0]        lres;

  logic                             side;
  logic signed [smb_pkg::X_W-1:0]   x;
  logic signed [smb_pkg::CAP_W-1:0] hp, lp;
  logic [smb_pkg::COEF_W-1:0]       coef;
  logic signed [21:0]               mop;
  logic signed [smb_pkg::CAP_W-1:0] hp_next, lp_next;
  logic [smb_pkg::OUT_W-1:0]        lp_out;
  logic                             emit_ok;
  logic                             advance;

  function automatic logic signed [22:0] rnd16(input logic signed [38:0] p);
    logic signed [38:0] s;
    s = p + 39'sd32768;
    return s[38:16];
  endfunction

  function automatic logic signed [smb_pkg::CAP_W-1:0] sat_cap(
    input logic signed [23:0] v
  );
    if (v > 24'sd524287) begin
      return 20'sd524287;
    end else if (v < -24'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  function automatic logic [smb_pkg::OUT_W-1:0] sat_out(
    input logic signed [smb_pkg::CAP_W-1:0] v
  );
    if (v > 20'sd32767) begin
      return 16'h7fff;
    end else if (v < -20'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  assign side    = phase[2];
  assign x       = side ? cur.right_x : cur.left_x;
  assign hp      = side ? rhp : lhp;
  assign lp      = side ? rlp : llp;
  assign coef    = phase[1] ? cfg.lp_coef : cfg.hp_coef;
  assign mop     = phase[1] ? (22'(x) - 22'(hp) - 22'(lp)) : (22'(x) - 22'(hp));
  assign hp_next = sat_cap(24'(x) - 24'(rnd16(prod)));
  assign lp_next = sat_cap(24'(lp) + 24'(rnd16(prod)));
  assign lp_out  = sat_out(lp_next);

  assign emit_ok = !out_valid || out_ready;
  assign pop     = (!busy || emit) && !qstat.empty;
  assign advance = busy && !cur.clear && (phase != LAST_PHASE || emit_ok);
  assign emit    = busy && emit_ok && (cur.clear || phase == LAST_PHASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
      lhp       <= '0;
      llp       <= '0;
      rhp       <= '0;
      rlp       <= '0;
    end else begin
      if (pop) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (emit) begin
        busy <= 1'b0;
      end else if (advance) begin
        phase <= phase + 3'd1;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (busy && cur.clear && emit_ok) begin
        lhp <= '0;
        llp <= '0;
        rhp <= '0;
        rlp <= '0;
      end else if (advance) begin
        unique case (phase[1:0])
          2'd1: begin
            if (side) rhp <= hp_next;
            else      lhp <= hp_next;
          end
          2'd3: begin
            if (side) rlp <= lp_next;
            else      llp <= lp_next;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance && !phase[0]) begin
      prod <= 39'(mop) * 39'($signed({1'b0, coef}));
    end
    if (advance && phase == 3'd3) begin
      lres <= lp_out;
    end
    if (emit) begin
      out_data <= cur.clear ? '0 : {lp_out, lres};
    end
  end

endmodule

### hw/rtl/stereo_mixer_bandpass.sv
// top level of the stereo mixer with high-pass and low-pass caps
// depends on smb_pkg, smb_front, smb_queue, smb_back and the assertion macros
//
// Each request carries four Q1.15 channel levels in tdata and the dacs-on flag in
// tuser. The front end takes one request per cycle while its stage is empty or the
// queue is not full, mixes and scales both sides into its stage register and drops
// requests while audio is off; a two-entry queue feeds the back end. For a request
// with dacs on the caps of each side go through four steps (multiply, high-pass
// update, multiply, low-pass update) on a single 22x17 multiplier, one request at a
// time. A request with dacs off clears all caps and gives a zero result. A request
// passes the front-end stage register and the queue before the back end takes it.
// The result register lets the next request start while a result waits.
`include "stereo_mixer_bandpass_macros.svh"
module stereo_mixer_bandpass (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // ch1_level, ch2_level, ch3_level, ch4_level
  input  logic        s_axis_tuser,  // dacs_on
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // right_out, left_out
  input  logic        cfg_we,
  input  logic [smb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [smb_pkg::CFG_DATA_W-1:0] cfg_data
);

  smb_pkg::cfg_t   cfg;
  smb_pkg::job_t   push_job;
  smb_pkg::job_t   head_job;
  smb_pkg::qstat_t qstat;
  logic            push;
  logic            pop;
  logic            emit;
  logic            req_accept;

  assign req_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_route    <= '0;
      cfg.left_volume  <= '0;
      cfg.right_volume <= '0;
      cfg.hp_coef      <= smb_pkg::HP_COEF_RESET;
      cfg.lp_coef      <= smb_pkg::LP_COEF_RESET;
      cfg.sound_en     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smb_pkg::REG_PAN_ROUTE:    cfg.pan_route    <= cfg_data[smb_pkg::PAN_W-1:0];
        smb_pkg::REG_LEFT_VOLUME:  cfg.left_volume  <= cfg_data[smb_pkg::VOL_W-1:0];
        smb_pkg::REG_RIGHT_VOLUME: cfg.right_volume <= cfg_data[smb_pkg::VOL_W-1:0];
        smb_pkg::REG_HP_COEF:      cfg.hp_coef      <= cfg_data;
        smb_pkg::REG_LP_COEF:      cfg.lp_coef      <= cfg_data;
        smb_pkg::REG_SOUND_EN:     cfg.sound_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  smb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .levels   (s_axis_tdata),
    .dacs_on  (s_axis_tuser),
    .qstat    (qstat),
    .push     (push),
    .job      (push_job)
  );

  smb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .qstat  (qstat)
  );

  smb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head_job),
    .qstat     (qstat),
    .pop       (pop),
    .emit      (emit),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // muted requests never reach the queue
  `SMB_ASSERT_NXT(a_mute_no_push, req_accept && !cfg.sound_en, !push, "muted request pushed")
  `SMB_ASSERT_IMP(a_push_not_full, push, !qstat.full, "push into full queue")
  `SMB_ASSERT_IMP(a_pop_not_empty, pop, !qstat.empty, "pop from empty queue")
  `SMB_ASSERT_IMP(a_result_from_back, $rose(m_axis_tvalid), $past(emit), "result without emit")

endmodule

### test/tb_top.sv
// self-checking bench for stereo_mixer_bandpass: a mixer tracker predicts each
// sample from the requests and register writes and compares every result
// depends on smb_pkg and the stereo_mixer_bandpass rtl
module tb_top;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int TARGET_REQUESTS = 1050;
  localparam int SETTLE_CYCLES   = 30;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam longint CAP_MAX     = 524287;
  localparam longint CAP_MIN     = -524288;
  localparam longint OUT_MAX     = 32767;
  localparam longint OUT_MIN     = -32768;
  localparam logic [smb_pkg::REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [smb_pkg::REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  class mixer_tracker;
    logic [smb_pkg::PAN_W-1:0]        pan_route;
    logic [smb_pkg::VOL_W-1:0]        left_volume;
    logic [smb_pkg::VOL_W-1:0]        right_volume;
    logic [smb_pkg::COEF_W-1:0]       hp_coef;
    logic [smb_pkg::COEF_W-1:0]       lp_coef;
    logic                             sound_en;
    logic signed [smb_pkg::CAP_W-1:0] left_hp;
    logic signed [smb_pkg::CAP_W-1:0] left_lp;
    logic signed [smb_pkg::CAP_W-1:0] right_hp;
    logic signed [smb_pkg::CAP_W-1:0] right_lp;
    logic [2*smb_pkg::OUT_W-1:0]      pending_samples[$];
    int                               mismatches;

    function new();
      pan_route = '0;
      left_volume = '0;
      right_volume = '0;
      hp_coef = smb_pkg::HP_COEF_RESET;
      lp_coef = smb_pkg::LP_COEF_RESET;
      sound_en = 1'b0;
      left_hp = '0;
      left_lp = '0;
      right_hp = '0;
      right_lp = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [smb_pkg::REG_IDX_W-1:0] idx,
                            logic [smb_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        smb_pkg::REG_PAN_ROUTE:    pan_route = data[smb_pkg::PAN_W-1:0];
        smb_pkg::REG_LEFT_VOLUME:  left_volume = data[smb_pkg::VOL_W-1:0];
        smb_pkg::REG_RIGHT_VOLUME: right_volume = data[smb_pkg::VOL_W-1:0];
        smb_pkg::REG_HP_COEF:      hp_coef = data[smb_pkg::COEF_W-1:0];
        smb_pkg::REG_LP_COEF:      lp_coef = data[smb_pkg::COEF_W-1:0];
        smb_pkg::REG_SOUND_EN:     sound_en = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic signed [smb_pkg::OUT_W-1:0] filter_side(
      longint sum, logic [smb_pkg::VOL_W-1:0] vol,
      inout logic signed [smb_pkg::CAP_W-1:0] hp,
      inout logic signed [smb_pkg::CAP_W-1:0] lp);
      longint x, hpn, h, lpn, kh, kl, gain, sample;
      kh = hp_coef;
      kl = lp_coef;
      gain = vol;
      gain = gain + 1;
      x = (16 - sum * gain) >>> 5;
      hpn = clamp(x - ((((x - hp) * kh) + 32768) >>> 16), CAP_MIN, CAP_MAX);
      h = x - hpn;
      lpn = clamp(lp + ((((h - lp) * kl) + 32768) >>> 16), CAP_MIN, CAP_MAX);
      hp = hpn[smb_pkg::CAP_W-1:0];
      lp = lpn[smb_pkg::CAP_W-1:0];
      sample = clamp(lpn, OUT_MIN, OUT_MAX);
      return sample[smb_pkg::OUT_W-1:0];
    endfunction

    function void take_request(logic [4*smb_pkg::LEVEL_W-1:0] levels, logic dacs);
      longint lsum, rsum, lev;
      logic signed [smb_pkg::OUT_W-1:0] l, r;
      if (!sound_en) return;
      l = '0;
      r = '0;
      if (!dacs) begin
        left_hp = '0;
        left_lp = '0;
        right_hp = '0;
        right_lp = '0;
      end else begin
        lsum = 0;
        rsum = 0;
        for (int i = 0; i < smb_pkg::NUM_CH; i++) begin
          lev = $signed(levels[i*smb_pkg::LEVEL_W +: smb_pkg::LEVEL_W]);
          if (pan_route[i]) rsum += lev;
          if (pan_route[i+smb_pkg::NUM_CH]) lsum += lev;
        end
        l = filter_side(lsum, left_volume, left_hp, left_lp);
        r = filter_side(rsum, right_volume, right_hp, right_lp);
      end
      pending_samples.push_back({r, l});
    endfunction

    function void check_sample(logic [2*smb_pkg::OUT_W-1:0] got);
      logic [2*smb_pkg::OUT_W-1:0] want;
      if (pending_samples.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected sample, expected none, actual left %0d right %0d", $time,
                 $signed(got[smb_pkg::OUT_W-1:0]),
                 $signed(got[2*smb_pkg::OUT_W-1:smb_pkg::OUT_W]));
        return;
      end
      want = pending_samples.pop_front();
      if (got[smb_pkg::OUT_W-1:0] !== want[smb_pkg::OUT_W-1:0]) begin
        mismatches++;
        $display("%0t: left_out expected %0d actual %0d", $time,
                 $signed(want[smb_pkg::OUT_W-1:0]), $signed(got[smb_pkg::OUT_W-1:0]));
      end
      if (got[2*smb_pkg::OUT_W-1:smb_pkg::OUT_W] !==
          want[2*smb_pkg::OUT_W-1:smb_pkg::OUT_W]) begin
        mismatches++;
        $display("%0t: right_out expected %0d actual %0d", $time,
                 $signed(want[2*smb_pkg::OUT_W-1:smb_pkg::OUT_W]),
                 $signed(got[2*smb_pkg::OUT_W-1:smb_pkg::OUT_W]));
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [63:0]                    s_axis_tdata = '0;  // ch1_level, ch2_level, ch3_level, ch4_level
  logic                           s_axis_tuser = 1'b0;  // dacs_on
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;  // right_out, left_out
  logic                           cfg_we = 1'b0;
  logic [smb_pkg::REG_IDX_W-1:0]  cfg_index = smb_pkg::REG_PAN_ROUTE;
  logic [smb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mixer_tracker tracker = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_stall = 0;
  int cycle_count = 0;

  stereo_mixer_bandpass u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [smb_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(-$urandom_range(0, 64));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [smb_pkg::CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // result side: check accepted samples, then decide the next stall
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_sample(m_axis_tdata);
    if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      rx_stall = pick_gap(rx_quiet);
      m_axis_tready <= (rx_stall == 0);
    end
  end

  task automatic set_reg(logic [smb_pkg::REG_IDX_W-1:0] idx,
                         logic [smb_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(logic [smb_pkg::CFG_DATA_W-1:0] pan,
                           logic [smb_pkg::CFG_DATA_W-1:0] lvol,
                           logic [smb_pkg::CFG_DATA_W-1:0] rvol,
                           logic [smb_pkg::CFG_DATA_W-1:0] hp,
                           logic [smb_pkg::CFG_DATA_W-1:0] lp,
                           logic [smb_pkg::CFG_DATA_W-1:0] on);
    set_reg(smb_pkg::REG_PAN_ROUTE, pan);
    set_reg(smb_pkg::REG_LEFT_VOLUME, lvol);
    set_reg(smb_pkg::REG_RIGHT_VOLUME, rvol);
    set_reg(smb_pkg::REG_HP_COEF, hp);
    set_reg(smb_pkg::REG_LP_COEF, lp);
    set_reg(smb_pkg::REG_SOUND_EN, on);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [smb_pkg::CFG_DATA_W-1:0] on;
    on = 16'($urandom_range(0, 65535));
    on[0] = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 3) == 0)
      set_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, pick_reg_value());
    configure(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
              pick_reg_value(), on);
  endtask

  task automatic send(logic [4*smb_pkg::LEVEL_W-1:0] levels, logic dacs);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= levels;
    s_axis_tuser <= dacs;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_request(levels, dacs);
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_empty(int settle);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    int n;
    int counted;
    logic [4*smb_pkg::LEVEL_W-1:0] levels;
    counted = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // audio is off after reset, so these are dropped
    send({4{16'h7FFF}}, 1'b1);
    send({4{16'h8000}}, 1'b1);
    send({4{16'h1234}}, 1'b0);
    wait_empty(SETTLE_CYCLES);

    configure(16'h00FF, 16'd7, 16'd7, smb_pkg::HP_COEF_RESET, smb_pkg::LP_COEF_RESET, 16'd1);
    send({4{16'h7FFF}}, 1'b1);
    send({4{16'h8000}}, 1'b1);
    send({4{16'h0000}}, 1'b1);
    send({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1);
    send({4{16'h7FFF}}, 1'b0);
    send({4{16'h7FFF}}, 1'b1);
    wait_empty(SETTLE_CYCLES);

    // charge the high-pass caps, then swing the other way to saturate
    configure(16'h00FF, 16'd7, 16'd7, 16'h0000, 16'h8000, 16'd1);
    send({4{16'h7FFF}}, 1'b1);
    send({4{16'h7FFF}}, 1'b1);
    wait_empty(SETTLE_CYCLES);
    configure(16'h00FF, 16'd7, 16'd7, 16'hFFFF, 16'hFFFF, 16'd1);
    send({4{16'h8000}}, 1'b1);
    send({4{16'h8000}}, 1'b1);
    wait_empty(SETTLE_CYCLES);
    configure(16'h00FF, 16'd7, 16'd7, 16'h0000, 16'hFFFF, 16'd1);
    send({4{16'h8000}}, 1'b1);
    send({4{16'h8000}}, 1'b1);
    wait_empty(SETTLE_CYCLES);
    configure(16'h00FF, 16'd7, 16'd7, 16'hFFFF, 16'hFFFF, 16'd1);
    send({4{16'h7FFF}}, 1'b1);
    send({4{16'h7FFF}}, 1'b1);
    wait_empty(SETTLE_CYCLES);

    // unmapped indexes and upper data bits must be ignored
    set_reg(REG_UNMAPPED_LO, 16'hFFFF);
    set_reg(REG_UNMAPPED_HI, 16'hFFFF);
    configure(16'hA55A, 16'hFFF8, 16'h0003, smb_pkg::HP_COEF_RESET, smb_pkg::LP_COEF_RESET,
              16'hFFFF);
    send({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, 1'b1);
    send({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001}, 1'b1);
    wait_empty(0);
    send({4{16'h5555}}, 1'b1);
    send({4{16'hAAAA}}, 1'b0);
    wait_empty(SETTLE_CYCLES);

    while (counted < TARGET_REQUESTS) begin
      random_config();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) wait_empty(0);
        levels = {pick_level(), pick_level(), pick_level(), pick_level()};
        send(levels, $urandom_range(0, 15) != 0);
        counted++;
      end
      wait_empty(SETTLE_CYCLES);
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
